### src/ncg_pkg.sv
// ----------------------------------------------------------------------------
// ncg_pkg
// Shared types and constants for the next combination generator: register
// indexes, default sizes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ncg_pkg;

   localparam int MAX_SELECT_DEF = 16;
   localparam int MAX_SET_DEF    = 256;

   // fixed field widths
   localparam int SLOT_W  = 4;
   localparam int INDEX_W = 8;
   localparam int SEL_W   = 5;
   localparam int SET_W   = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // largest k the result channel can carry
   localparam int SLOT_LIMIT = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SELECT_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_SIZE     = 1'd1;

   localparam logic [SEL_W-1:0] SELECT_COUNT_RST = 5'd1;
   localparam logic [SET_W-1:0] SET_SIZE_RST     = 9'd16;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_EMIT   = 3'b100
   } ncg_state_type;

   typedef struct packed {
      logic load;         // reload 0..k-1 and start emitting
      logic search_init;  // start the search at the last position
      logic search_step;  // one search position this cycle
      logic emit;         // send one result beat this cycle
   } ncg_cmd_type;

   typedef struct packed {
      logic hit;          // current search position can advance
      logic pos_zero;     // search sits at position 0
      logic emit_last;    // current beat is the final position
      logic out_free;     // result register can take a beat
   } ncg_status_type;

endpackage

### src/ncg_ctrl.sv
// ----------------------------------------------------------------------------
// ncg_ctrl
// Controller: accepts step requests, keeps the started flag and sequences the
// datapath through search and emit phases.
// ----------------------------------------------------------------------------
module ncg_ctrl
   import ncg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_restart,
   input  ncg_status_type status,
   output ncg_cmd_type    cmd
);

   ncg_state_type state_ff, state_in;
   logic          started_ff, started_in;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_restart || !started_ff) begin
                  cmd.load   = 1'b1;
                  started_in = 1'b1;
                  state_in   = ST_EMIT;
               end else begin
                  cmd.search_init = 1'b1;
                  state_in        = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.hit || status.pos_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

endmodule

### src/ncg_datapath.sv
// ----------------------------------------------------------------------------
// ncg_datapath
// Datapath: combination store, search pointer, refill counter and the result
// register. Positions from the advance point onward are rewritten while they
// are emitted.
// ----------------------------------------------------------------------------
module ncg_datapath
   import ncg_pkg::*;
#(
   parameter int KMAX = MAX_SELECT_DEF,
   localparam int IW  = (KMAX > 1) ? $clog2(KMAX) : 1
)
(
   input  logic               clock,
   input  logic               reset,
   input  ncg_cmd_type        cmd,
   output ncg_status_type     status,
   input  logic [IW-1:0]      km1,
   input  logic [SET_W-1:0]   n_eff,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [INDEX_W-1:0] rsp_chosen_index,
   output logic               rsp_last_of_step,
   output logic               rsp_exhausted
);

   logic [INDEX_W-1:0] store_ff [KMAX];

   logic [IW-1:0]      pos_ff, pos_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      adv_ff, adv_in;
   logic [INDEX_W-1:0] run_ff, run_in;
   logic               exh_ff, exh_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_exh_ff, rsp_exh_in;

   logic [IW-1:0]      rd_addr;
   logic [INDEX_W-1:0] rd_data;
   logic [IW-1:0]      pos_gap;
   logic [9:0]         need;
   logic               use_run;
   logic [INDEX_W-1:0] beat_value;
   logic               wr_en;

   assign rd_addr = cmd.search_step ? pos_ff : idx_ff;
   assign rd_data = store_ff[rd_addr];

   // position can advance when value + distance from end + 2 <= n
   assign pos_gap = km1 - pos_ff;
   assign need    = {2'b00, rd_data} + 10'(pos_gap) + 10'd2;

   assign status.hit       = (need <= {1'b0, n_eff});
   assign status.pos_zero  = (pos_ff == '0);
   assign status.emit_last = (idx_ff == km1);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign use_run    = !exh_ff && (idx_ff >= adv_ff);
   assign beat_value = use_run ? run_ff : rd_data;
   assign wr_en      = cmd.emit && use_run;

   always_comb begin
      pos_in = pos_ff;
      idx_in = idx_ff;
      adv_in = adv_ff;
      run_in = run_ff;
      exh_in = exh_ff;
      if (cmd.load) begin
         idx_in = '0;
         adv_in = '0;
         run_in = '0;
         exh_in = 1'b0;
      end else if (cmd.search_init) begin
         pos_in = km1;
      end else if (cmd.search_step) begin
         if (status.hit) begin
            adv_in = pos_ff;
            run_in = rd_data + 8'd1;
            exh_in = 1'b0;
            idx_in = '0;
         end else if (status.pos_zero) begin
            exh_in = 1'b1;
            idx_in = '0;
         end else begin
            pos_in = pos_ff - IW'(1);
         end
      end else if (cmd.emit) begin
         idx_in = idx_ff + IW'(1);
         if (use_run) begin
            run_in = run_ff + 8'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_exh_in   = rsp_exh_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = SLOT_W'(idx_ff);
         rsp_index_in = beat_value;
         rsp_last_in  = status.emit_last;
         rsp_exh_in   = exh_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[idx_ff] <= run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      adv_ff       <= adv_in;
      run_ff       <= run_in;
      exh_ff       <= exh_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_last_of_step = rsp_last_ff;
   assign rsp_exhausted    = rsp_exh_ff;

endmodule

### src/next_combination_generator.sv
// ----------------------------------------------------------------------------
// next_combination_generator
// Steps a k-subset of {0..n-1} through lexicographic order, one step per
// request beat, and streams the k indices of each step as result beats.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_restart
//   rsp_      out        rsp_valid/rsp_ready   rsp_slot, rsp_chosen_index,
//                                              rsp_last_of_step, rsp_exhausted
//   csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// A load step goes straight to emitting the k beats; an advance first searches
// the store right to left, one position at a time, then emits the k beats.
// One request is in flight at a time; req_ready is high only while idle.
// Result beats leave one per cycle; rsp_ready low holds the emit sequence.
// Reset clears control and the registers to k=1, n=16; the store is not
// cleared and the first step after reset is always a load.
// ----------------------------------------------------------------------------
module next_combination_generator
   import ncg_pkg::*;
#(
   parameter int MAX_SELECT = MAX_SELECT_DEF,
   parameter int MAX_SET    = MAX_SET_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_restart,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [INDEX_W-1:0]    rsp_chosen_index,
   output logic                  rsp_last_of_step,
   output logic                  rsp_exhausted,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KMAX = (MAX_SELECT < SLOT_LIMIT) ? MAX_SELECT : SLOT_LIMIT;
   localparam int IW   = (KMAX > 1) ? $clog2(KMAX) : 1;

   logic [SEL_W-1:0] select_count_ff, select_count_in;
   logic [SET_W-1:0] set_size_ff, set_size_in;
   logic [SEL_W-1:0] k_sat;
   logic [IW-1:0]    km1;
   logic [SET_W-1:0] n_eff;

   ncg_cmd_type    cmd;
   ncg_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      select_count_in = select_count_ff;
      set_size_in     = set_size_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SELECT_COUNT: select_count_in = csr_wdata[SEL_W-1:0];
            CSR_SET_SIZE:     set_size_in     = csr_wdata[SET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_count_ff <= SELECT_COUNT_RST;
         set_size_ff     <= SET_SIZE_RST;
      end else begin
         select_count_ff <= select_count_in;
         set_size_ff     <= set_size_in;
      end
   end

   // k clamped to 1..KMAX, kept as k-1
   always_comb begin
      if (select_count_ff == '0) begin
         k_sat = 5'd1;
      end else if (32'(select_count_ff) > KMAX) begin
         k_sat = SEL_W'(KMAX);
      end else begin
         k_sat = select_count_ff;
      end
   end
   assign km1 = IW'(k_sat - 5'd1);

   // n clamped to 1..MAX_SET
   always_comb begin
      if (set_size_ff == '0) begin
         n_eff = 9'd1;
      end else if (32'(set_size_ff) > MAX_SET) begin
         n_eff = SET_W'(MAX_SET);
      end else begin
         n_eff = set_size_ff;
      end
   end

   ncg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .status      (status),
      .cmd         (cmd)
   );

   ncg_datapath #(
      .KMAX (KMAX)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .km1              (km1),
      .n_eff            (n_eff),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_slot         (rsp_slot),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_exhausted    (rsp_exhausted)
   );

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the next combination generator. Steps are sent as request
// beats; a local copy of the combination store predicts the k index beats of
// every step, and a checker compares them field by field as they come out.
// Runs directed register and corner-case tests, a full walk at k=1, then
// random phases with random sizes and random idle cycles.
// ----------------------------------------------------------------------------
module tb_top
   import ncg_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 110;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [INDEX_W-1:0] chosen_index;
      logic               last_of_step;
      logic               exhausted;
   } index_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_restart = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SLOT_W-1:0]     rsp_slot;
   logic [INDEX_W-1:0]    rsp_chosen_index;
   logic                  rsp_last_of_step;
   logic                  rsp_exhausted;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SELECT_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted combination state
   logic [INDEX_W-1:0] model_combo [MAX_SELECT_DEF];
   bit                 model_loaded = 1'b0;
   int                 model_written = 0;
   logic [SEL_W-1:0]   model_select = SELECT_COUNT_RST;
   logic [SET_W-1:0]   model_set = SET_SIZE_RST;

   index_beat_type pending_beats [$];
   int  fail_count = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   int  ready_hold = 0;
   bit  quiet_mode = 1'b0;

   next_combination_generator #(
      .MAX_SELECT (MAX_SELECT_DEF),
      .MAX_SET    (MAX_SET_DEF)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot         (rsp_slot),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_exhausted    (rsp_exhausted),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int active_select();
      int k;
      k = int'(model_select);
      if (k < 1) k = 1;
      if (k > MAX_SELECT_DEF) k = MAX_SELECT_DEF;
      if (k > SLOT_LIMIT) k = SLOT_LIMIT;
      return k;
   endfunction

   function automatic int active_set();
      int n;
      n = int'(model_set);
      if (n < 1) n = 1;
      if (n > MAX_SET_DEF) n = MAX_SET_DEF;
      return n;
   endfunction

   // one step of the lexicographic walk, queues the k index beats it yields
   function automatic void step_combination(input bit restart);
      int k;
      int n;
      int pos;
      bit is_load;
      bit found;
      index_beat_type beat;
      k = active_select();
      n = active_set();
      is_load = restart || !model_loaded;
      found = 1'b0;
      if (is_load) begin
         for (int i = 0; i < k; i++) model_combo[i] = INDEX_W'(i);
         model_loaded = 1'b1;
         if (k > model_written) model_written = k;
      end else begin
         for (int f = 0; f < k && !found; f++) begin
            pos = k - 1 - f;
            // position may still move if below n-k+pos
            if (int'(model_combo[pos]) <= n - 2 - f) begin
               model_combo[pos] = model_combo[pos] + 8'd1;
               for (int j = pos + 1; j < k; j++) model_combo[j] = model_combo[j-1] + 8'd1;
               found = 1'b1;
            end
         end
      end
      for (int i = 0; i < k; i++) begin
         beat.slot = SLOT_W'(i);
         beat.chosen_index = model_combo[i];
         beat.last_of_step = (i == k - 1);
         beat.exhausted = !is_load && !found;
         pending_beats.insert(pending_beats.size(), beat);
      end
   endfunction

   function automatic int draw_gap();
      return quiet_mode ? 0 : $urandom_range(0, 7);
   endfunction

   // result side: random stalls, field by field compare
   always @(posedge clock) begin : check_beats
      index_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual slot %0d index %0d",
                        $time, rsp_slot, rsp_chosen_index);
               fail_count++;
            end else begin
               want = pending_beats.pop_front();
               if (rsp_slot !== want.slot) begin
                  $display("%0t: slot mismatch, expected %0d, actual %0d",
                           $time, want.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_chosen_index !== want.chosen_index) begin
                  $display("%0t: chosen_index mismatch, expected %0d, actual %0d",
                           $time, want.chosen_index, rsp_chosen_index);
                  fail_count++;
               end
               if (rsp_last_of_step !== want.last_of_step) begin
                  $display("%0t: last_of_step mismatch, expected %0b, actual %0b",
                           $time, want.last_of_step, rsp_last_of_step);
                  fail_count++;
               end
               if (rsp_exhausted !== want.exhausted) begin
                  $display("%0t: exhausted mismatch, expected %0b, actual %0b",
                           $time, want.exhausted, rsp_exhausted);
                  fail_count++;
               end
            end
            ready_hold = draw_gap();
         end
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_step(input bit restart);
      int gap;
      bit do_restart;
      gap = draw_gap();
      do_restart = restart;
      // an advance after k grew would read positions never loaded
      if (model_loaded && active_select() > model_written) do_restart = 1'b1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= do_restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      step_combination(do_restart);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SELECT_COUNT) model_select = data[SEL_W-1:0];
      else model_set = data[SET_W-1:0];
   endtask

   // default sizes, first step after reset loads even without restart
   task automatic test_reset_state();
      send_step(1'b0);
      send_step(1'b0);
      send_step(1'b0);
      send_step(1'b1);
   endtask

   task automatic test_size_limits();
      write_reg(CSR_SELECT_COUNT, 9'd16);
      write_reg(CSR_SET_SIZE, 9'd256);
      send_step(1'b1);
      send_step(1'b0);
      send_step(1'b0);
      // shrink n under the stored values, nothing can advance
      write_reg(CSR_SET_SIZE, 9'd16);
      send_step(1'b0);
      send_step(1'b1);
      send_step(1'b0);
   endtask

   task automatic test_register_saturation();
      write_reg(CSR_SELECT_COUNT, 9'd0);
      write_reg(CSR_SET_SIZE, 9'd0);
      send_step(1'b1);
      send_step(1'b0);
      write_reg(CSR_SELECT_COUNT, 9'h1ff);
      write_reg(CSR_SET_SIZE, 9'h1ff);
      send_step(1'b1);
      send_step(1'b0);
      // upper data bits are dropped for the 5-bit register
      write_reg(CSR_SELECT_COUNT, 9'h1e0);
      send_step(1'b1);
   endtask

   task automatic test_select_above_size();
      write_reg(CSR_SELECT_COUNT, 9'd5);
      write_reg(CSR_SET_SIZE, 9'd3);
      send_step(1'b1);
      send_step(1'b0);
      send_step(1'b0);
   endtask

   task automatic test_size_change();
      write_reg(CSR_SELECT_COUNT, 9'd3);
      write_reg(CSR_SET_SIZE, 9'd8);
      send_step(1'b1);
      repeat (3) send_step(1'b0);
      write_reg(CSR_SET_SIZE, 9'd4);
      send_step(1'b0);
      send_step(1'b0);
      write_reg(CSR_SELECT_COUNT, 9'd4);
      send_step(1'b1);
   endtask

   // k=1 over a 64-entry set reaches every index value and ends exhausted
   task automatic test_full_walk();
      write_reg(CSR_SELECT_COUNT, 9'd1);
      write_reg(CSR_SET_SIZE, 9'd64);
      quiet_mode = 1'b1;
      send_step(1'b1);
      for (int i = 0; i < 64; i++) begin
         if (i == 32) quiet_mode = 1'b0;
         send_step(1'b0);
      end
      wait_drained();
   endtask

   task automatic test_random_walks();
      int stop_at;
      int pick;
      int len;
      bit keep_going;
      bit noisy;
      bit restart;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         keep_going = ($urandom_range(0, 3) == 0);
         if (keep_going) begin
            // new n on the stored combination, no reload
            write_reg(CSR_SET_SIZE, CSR_DATA_W'($urandom_range(1, 12)));
         end else if (pick == 0) begin
            write_reg(CSR_SELECT_COUNT, CSR_DATA_W'($urandom_range(0, 511)));
            write_reg(CSR_SET_SIZE, CSR_DATA_W'($urandom_range(0, 511)));
         end else if (pick == 1) begin
            write_reg(CSR_SELECT_COUNT, 9'd16);
            write_reg(CSR_SET_SIZE, CSR_DATA_W'($urandom_range(14, 20)));
         end else begin
            write_reg(CSR_SELECT_COUNT, CSR_DATA_W'($urandom_range(1, 5)));
            write_reg(CSR_SET_SIZE, CSR_DATA_W'($urandom_range(1, 9)));
         end
         quiet_mode = ($urandom_range(0, 3) == 0);
         noisy = ($urandom_range(0, 7) == 0);
         len = $urandom_range(5, 30);
         for (int i = 0; i < len; i++) begin
            if (i == 0 && !keep_going) restart = 1'b1;
            else if (noisy) restart = ($urandom_range(0, 1) == 1);
            else restart = ($urandom_range(0, 15) == 0);
            send_step(restart);
         end
         wait_drained();
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_size_limits();
      test_register_saturation();
      test_select_above_size();
      test_size_change();
      test_full_walk();
      test_random_walks();
      wait_drained();
      repeat (50) @(posedge clock);
      if (pending_beats.size() != 0) begin
         $display("%0t: %0d beats never arrived", $time, pending_beats.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
